[hw/rtl/http_request_line_checker_macros.svh]
// Assertion helpers for the request line checker.
// Every check is clocked on clk and held off while rst_n is low.
`ifndef HTTP_REQUEST_LINE_CHECKER_MACROS_SVH
`define HTTP_REQUEST_LINE_CHECKER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define HRLC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("request line checker: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define HRLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("request line checker: next-cycle check failed");

`endif

[hw/rtl/hrlc_pkg.sv]
`default_nettype none
package hrlc_pkg;

  // Parser phase within one request
  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_URI     = 3'd1,
    PH_VERSION = 3'd2,
    PH_NOSPACE = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  // Result codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_REQ  = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_NOT_IMPL = 2'd3
  } status_t;

  // Progress through the CR LF CR LF terminator
  typedef enum logic [1:0] {
    CT_NONE   = 2'd0,
    CT_CR     = 2'd1,
    CT_CRLF   = 2'd2,
    CT_CRLFCR = 2'd3
  } crlf_t;

  // Field check state of the request line
  typedef struct packed {
    phase_t     phase;
    logic [1:0] method_idx;
    logic       method_bad;
    logic       uri_first_seen;
    logic       uri_bad;
    logic [2:0] version_idx;
    logic       version_bad;
  } fld_t;

  localparam int unsigned DEF_COUNT_BITS   = 17;
  localparam logic [15:0] DEF_MAX_LINE_LEN = 16'd1023;

  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_SP    = 8'h20;
  localparam logic [7:0] CHR_SLASH = 8'h2F;

  localparam logic [1:0] METHOD_LEN  = 2'd3;
  localparam logic [2:0] VERSION_LEN = 3'd5;

  localparam fld_t FLD_CLEAR = '{
    phase: PH_METHOD, method_idx: 2'd0, method_bad: 1'b0, uri_first_seen: 1'b0,
    uri_bad: 1'b0, version_idx: 3'd0, version_bad: 1'b0
  };

  // "GET"
  function automatic logic [7:0] method_char(logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      default: c = 8'h54;
    endcase
    return c;
  endfunction

  // "HTTP/"
  function automatic logic [7:0] version_char(logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      default: c = 8'h2F;
    endcase
    return c;
  endfunction

  // One byte of the request line through the field checks
  function automatic fld_t line_byte(fld_t s, logic [7:0] b);
    fld_t r;
    r = s;
    unique case (s.phase)
      PH_METHOD: begin
        if (b == CHR_SP) begin
          if (s.method_idx != METHOD_LEN) r.method_bad = 1'b1;
          r.phase = PH_URI;
        end else if (s.method_idx < METHOD_LEN && b == method_char(s.method_idx)) begin
          r.method_idx = s.method_idx + 2'd1;
        end else begin
          r.method_bad = 1'b1;
        end
      end
      PH_URI: begin
        if (!s.uri_first_seen) begin
          r.uri_first_seen = 1'b1;
          if (b != CHR_SLASH) r.uri_bad = 1'b1;
        end
        if (b == CHR_SP) r.phase = PH_VERSION;
      end
      PH_VERSION: begin
        if (s.version_idx < VERSION_LEN) begin
          if (b != version_char(s.version_idx)) r.version_bad = 1'b1;
          r.version_idx = s.version_idx + 3'd1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // CR LF closing the request line
  function automatic fld_t line_end(fld_t s);
    fld_t r;
    r = s;
    if (s.phase == PH_METHOD) begin
      r.phase = PH_NOSPACE;
    end else begin
      if (s.phase == PH_URI && !s.uri_first_seen) r.uri_bad = 1'b1;
      if (s.phase == PH_VERSION && s.version_idx < VERSION_LEN) r.version_bad = 1'b1;
      r.phase = PH_DONE;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/http_request_line_checker.sv]
// HTTP request line checker: takes one request byte per clock on the in_ stream and,
// in the cycle after the beat flagged tlast, presents a single status beat (0 accepted,
// 1 bad request, 2 request line longer than the cfg_ limit, 3 method other than GET).
// Each byte is folded into the parse state by one short combinational pass between
// the state registers and the result register, so the block sustains one byte per
// cycle; the input stalls only while a finished status waits to be taken. Bytes from
// a NUL up to tlast are ignored. cfg_data sets the maximum line length (reset 1023)
// and is to be written between requests.
`default_nettype none
module http_request_line_checker #(
  parameter int unsigned COUNT_BITS = hrlc_pkg::DEF_COUNT_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request bytes
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last
  // status results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [1:0] status, [7:2] zero
  // line length limit
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data    // max_line_len
);
  import hrlc_pkg::*;

  localparam int unsigned CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] COUNT_CAP = {COUNT_BITS{1'b1}};

  logic [15:0]           max_len_r;
  fld_t                  fld_r, fld_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  crlf_t                 crlf_r, crlf_nxt;
  logic                  found_r, found_nxt;
  logic                  nul_r, nul_nxt;
  logic                  out_valid_r;
  status_t               out_status_r, status_nxt;

  logic                  in_beat;
  logic                  out_beat;
  fld_t                  fld_a;
  logic [1:0]            inc;
  logic [COUNT_BITS:0]   count_sum;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_beat    = in_tvalid && in_tready;
  assign out_beat   = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r};
  assign cfg_ready  = 1'b1;

  // Per-byte parse: terminator tracking, held-back CR, field checks, length
  always_comb begin
    fld_nxt    = fld_r;
    count_nxt  = count_r;
    crlf_nxt   = crlf_r;
    found_nxt  = found_r;
    nul_nxt    = nul_r;
    fld_a      = fld_r;
    inc        = 2'd0;
    count_sum  = '0;
    status_nxt = ST_OK;

    if (in_beat && !nul_r) begin
      if (in_tdata == CHR_NUL) begin
        nul_nxt = 1'b1;
      end else begin
        priority if (in_tdata == CHR_CR) begin
          crlf_nxt = (crlf_r == CT_CRLF) ? CT_CRLFCR : CT_CR;
        end else if (in_tdata == CHR_LF && crlf_r == CT_CR) begin
          crlf_nxt = CT_CRLF;
        end else if (in_tdata == CHR_LF && crlf_r == CT_CRLFCR) begin
          crlf_nxt  = CT_NONE;
          found_nxt = 1'b1;
        end else begin
          crlf_nxt = CT_NONE;
        end

        if (fld_r.phase < PH_NOSPACE) begin
          if (crlf_r == CT_CR && in_tdata == CHR_LF) begin
            fld_nxt = line_end(fld_r);
          end else begin
            // a held CR that was not part of CR LF belongs to the line
            if (crlf_r == CT_CR) begin
              fld_a = line_byte(fld_r, CHR_CR);
            end
            fld_nxt = (in_tdata != CHR_CR) ? line_byte(fld_a, in_tdata) : fld_a;
            inc = {1'b0, crlf_r == CT_CR} + {1'b0, in_tdata != CHR_CR};
            count_sum = {1'b0, count_r} + {{(COUNT_BITS-1){1'b0}}, inc};
            count_nxt = count_sum[COUNT_BITS] ? COUNT_CAP : count_sum[COUNT_BITS-1:0];
          end
        end
      end
    end

    // Status on the final byte, then start afresh
    if (in_beat && in_tlast) begin
      priority if (!found_nxt) begin
        status_nxt = ST_BAD_REQ;
      end else if (CMP_W'(count_nxt) > CMP_W'(max_len_r)) begin
        status_nxt = ST_TOO_LONG;
      end else if (fld_nxt.phase == PH_NOSPACE) begin
        status_nxt = ST_BAD_REQ;
      end else if (fld_nxt.method_bad) begin
        status_nxt = ST_NOT_IMPL;
      end else if (fld_nxt.uri_bad || fld_nxt.version_bad) begin
        status_nxt = ST_BAD_REQ;
      end else begin
        status_nxt = ST_OK;
      end
      fld_nxt   = FLD_CLEAR;
      count_nxt = '0;
      crlf_nxt  = CT_NONE;
      found_nxt = 1'b0;
      nul_nxt   = 1'b0;
    end
  end

  // Parse state and limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= DEF_MAX_LINE_LEN;
      fld_r     <= FLD_CLEAR;
      count_r   <= '0;
      crlf_r    <= CT_NONE;
      found_r   <= 1'b0;
      nul_r     <= 1'b0;
    end else begin
      if (cfg_valid) max_len_r <= cfg_data;
      fld_r   <= fld_nxt;
      count_r <= count_nxt;
      crlf_r  <= crlf_nxt;
      found_r <= found_nxt;
      nul_r   <= nul_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_beat && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_beat) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && in_tlast) out_status_r <= status_nxt;
  end

  `include "http_request_line_checker_macros.svh"

  `HRLC_ASSERT_SAME(a_ready_when_empty, !out_valid_r, in_tready)
  `HRLC_ASSERT_NEXT(a_last_gives_result, in_beat && in_tlast, out_valid_r)
  `HRLC_ASSERT_NEXT(a_no_spurious_result, out_beat && !(in_beat && in_tlast), !out_valid_r)
  `HRLC_ASSERT_NEXT(a_cleared_after_last, in_beat && in_tlast,
                    fld_r.phase == PH_METHOD && count_r == '0 && !found_r && !nul_r)

endmodule
`default_nettype wire

[dv/http_request_line_checker_tb.sv]
`default_nettype none

import hrlc_pkg::*;

// Expected status per request, kept from the input beats as they are accepted
class status_scoreboard;
  logic [15:0]               line_limit;
  phase_t                    ph;
  logic [DEF_COUNT_BITS-1:0] line_len;
  logic [1:0]                verb_pos;
  logic                      verb_bad;
  logic                      uri_started;
  logic                      uri_bad;
  logic [2:0]                proto_pos;
  logic                      proto_bad;
  crlf_t                     crlf;
  logic                      term_seen;
  logic                      nul_hit;
  status_t                   expected_q[$];
  int                        errors;
  string                     verb_text;
  string                     proto_text;

  function new();
    verb_text  = "GET";
    proto_text = "HTTP/";
    line_limit = DEF_MAX_LINE_LEN;
    errors     = 0;
    clear_parse();
  endfunction

  function void clear_parse();
    ph          = PH_METHOD;
    line_len    = '0;
    verb_pos    = '0;
    verb_bad    = 1'b0;
    uri_started = 1'b0;
    uri_bad     = 1'b0;
    proto_pos   = '0;
    proto_bad   = 1'b0;
    crlf        = CT_NONE;
    term_seen   = 1'b0;
    nul_hit     = 1'b0;
  endfunction

  // One byte of the request line through method, URI and version checks
  function void field_byte(logic [7:0] b);
    if (!(&line_len)) line_len++;
    case (ph)
      PH_METHOD: begin
        if (b == CHR_SP) begin
          if (verb_pos != METHOD_LEN) verb_bad = 1'b1;
          ph = PH_URI;
        end else if (verb_pos < METHOD_LEN && b == verb_text[verb_pos]) begin
          verb_pos++;
        end else begin
          verb_bad = 1'b1;
        end
      end
      PH_URI: begin
        if (!uri_started) begin
          uri_started = 1'b1;
          if (b != CHR_SLASH) uri_bad = 1'b1;
        end
        if (b == CHR_SP) ph = PH_VERSION;
      end
      PH_VERSION: begin
        if (proto_pos < VERSION_LEN) begin
          if (b != proto_text[proto_pos]) proto_bad = 1'b1;
          proto_pos++;
        end
      end
      default: ;
    endcase
  endfunction

  function void note_byte(logic [7:0] b, logic last);
    crlf_t   prev;
    status_t st;
    if (!nul_hit) begin
      if (b == CHR_NUL) begin
        nul_hit = 1'b1;
      end else begin
        // terminator tracking
        prev = crlf;
        if (b == CHR_CR) begin
          crlf = (prev == CT_CRLF) ? CT_CRLFCR : CT_CR;
        end else if (b == CHR_LF && prev == CT_CR) begin
          crlf = CT_CRLF;
        end else if (b == CHR_LF && prev == CT_CRLFCR) begin
          crlf      = CT_NONE;
          term_seen = 1'b1;
        end else begin
          crlf = CT_NONE;
        end
        // still inside the request line: a CR is held until we know it is not CR LF
        if (ph < PH_NOSPACE) begin
          if (prev == CT_CR && b == CHR_LF) begin
            if (ph == PH_METHOD) begin
              ph = PH_NOSPACE;
            end else begin
              if (ph == PH_URI && !uri_started) uri_bad = 1'b1;
              if (ph == PH_VERSION && proto_pos < VERSION_LEN) proto_bad = 1'b1;
              ph = PH_DONE;
            end
          end else begin
            if (prev == CT_CR) field_byte(CHR_CR);
            if (b != CHR_CR) field_byte(b);
          end
        end
      end
    end
    if (last) begin
      if (!term_seen)                         st = ST_BAD_REQ;
      else if (line_len > line_limit)         st = ST_TOO_LONG;
      else if (ph == PH_NOSPACE)              st = ST_BAD_REQ;
      else if (verb_bad)                      st = ST_NOT_IMPL;
      else if (uri_bad || proto_bad)          st = ST_BAD_REQ;
      else                                    st = ST_OK;
      expected_q.push_back(st);
      clear_parse();
    end
  endfunction

  task report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task check_status(logic [1:0] got);
    status_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("status %0d with nothing expected", got));
    end else begin
      want = expected_q.pop_front();
      if (got != want) report_mismatch($sformatf("status %0d, expected %0d", got, want));
    end
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data   = '0;

  status_scoreboard sb = new();

  int         tx_idle = 0;
  int         rx_idle = 0;
  int         sent_bytes = 0;
  int         idle_cycles = 0;
  logic [7:0] req_bytes[$];

  http_request_line_checker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle);
  end

  // beat monitors
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
    if (rst_n && cfg_valid && cfg_ready) sb.line_limit = cfg_data;
    if (rst_n && out_tvalid && out_tready) sb.check_status(out_tdata[1:0]);
  end

  // watchdog on cycles with no beat anywhere
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_request();
    foreach (req_bytes[i]) send_byte(req_bytes[i], i == req_bytes.size() - 1);
    sent_bytes += req_bytes.size();
    req_bytes.delete();
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endtask

  // wait for every status, then wait out ignored trailing bytes
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(logic [15:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_char();
    if ($urandom_range(4) != 0) return 8'($urandom_range(126, 33));
    return 8'($urandom_range(255));
  endfunction

  // mostly well-formed requests with random content, some noise and cut-offs
  task automatic build_random();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 12) begin
      n = $urandom_range(24, 1);
      repeat (n) begin
        if ($urandom_range(3) == 0) req_bytes.push_back($urandom_range(1) ? CHR_CR : CHR_LF);
        else req_bytes.push_back(8'($urandom_range(255)));
      end
    end else begin
      case ($urandom_range(9))
        7:       push_text("GE");
        8:       push_text("GETS");
        9:       repeat ($urandom_range(5, 1)) req_bytes.push_back(rand_char());
        default: push_text("GET");
      endcase
      req_bytes.push_back(CHR_SP);
      if ($urandom_range(9) != 0) req_bytes.push_back(CHR_SLASH);
      repeat ($urandom_range(10)) req_bytes.push_back(rand_char());
      if ($urandom_range(3) != 0) begin
        req_bytes.push_back(CHR_SP);
        if ($urandom_range(7) != 0) push_text("HTTP/1.");
        else repeat ($urandom_range(6)) req_bytes.push_back(rand_char());
        req_bytes.push_back(8'($urandom_range(8'h39, 8'h30)));
      end
      push_text("\r\n");
      repeat ($urandom_range(2)) begin
        push_text("Host: ");
        repeat ($urandom_range(6, 1)) req_bytes.push_back(rand_char());
        push_text("\r\n");
      end
      push_text("\r\n");
      if ($urandom_range(9) == 0)
        req_bytes[$urandom_range(req_bytes.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(4, 1)) req_bytes.push_back(8'($urandom_range(255)));
      // cut-off request
      if (r >= 88) begin
        n = $urandom_range(req_bytes.size(), 1);
        while (req_bytes.size() > n) void'(req_bytes.pop_back());
      end
    end
  endtask

  task automatic random_phase(int n_bytes);
    int target;
    target = sent_bytes + n_bytes;
    while (sent_bytes < target) begin
      build_random();
      send_request();
    end
  endtask

  task automatic long_line(int n);
    push_text("GET /");
    repeat (n - 5) req_bytes.push_back(8'h61);
    push_text("\r\n\r\n");
    send_request();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle = 37;
    rx_idle = 57;

    // directed requests at the reset limit
    push_text("GET / HTTP/1.1\r\n\r\n");                 send_request();
    push_text("GET /index.html\r\nHost: a\r\n\r\n");    send_request();
    push_text("GET / HTTP/1.1\r\n");                     send_request();
    push_text("POST / HTTP/1.1\r\n\r\n");                send_request();
    push_text("GETX / HTTP/1.1\r\n\r\n");                send_request();
    push_text("GE / HTTP/1.1\r\n\r\n");                  send_request();
    push_text("GET\r\n\r\n");                            send_request();
    push_text("GET index HTTP/1.1\r\n\r\n");             send_request();
    push_text("GET  HTTP/1.1\r\n\r\n");                  send_request();
    push_text("GET \r\n\r\n");                           send_request();
    push_text("GET / HTT\r\n\r\n");                      send_request();
    push_text("GET / XTTP/1.1\r\n\r\n");                 send_request();
    push_text("GET /a\rb HTTP/1.1\r\n\r\n");             send_request();
    push_text("G\rET / HTTP/1.1\r\n\r\n");               send_request();
    push_text("GET /\r\n\r\r\n");                        send_request();
    push_text("\r\n\r\n");                               send_request();
    // zero byte after the terminator, and before it
    push_text("GET / HTTP/1.1\r\n\r\n");
    req_bytes.push_back(CHR_NUL);
    push_text("zz\r\n");                                 send_request();
    push_text("GET /");
    req_bytes.push_back(CHR_NUL);
    push_text("\r\n\r\n");                               send_request();
    req_bytes.push_back(CHR_NUL);                        send_request();
    req_bytes.push_back(8'hFF);                          send_request();
    push_text("GET /");
    req_bytes.push_back(8'hFF);
    req_bytes.push_back(8'h80);
    push_text(" HTTP/1.1\r\n\r\n");                      send_request();

    // line length at and just past the limit
    set_limit(16'd14);
    push_text("GET / HTTP/1.1\r\n\r\n");                 send_request();
    push_text("GET / HTTP/1.12\r\n\r\n");                send_request();
    // limit of zero: only an empty line passes the length check
    set_limit(16'd0);
    push_text("\r\n\r\n");                               send_request();
    push_text("G\r\n\r\n");                              send_request();
    set_limit(16'd1);
    push_text("G\r\n\r\n");                              send_request();
    push_text("GE\r\n\r\n");                             send_request();

    // random traffic under three idling patterns
    set_limit(16'($urandom_range(48, 8)));
    random_phase(420);

    set_limit(16'($urandom_range(48, 8)));
    tx_idle = 57;
    rx_idle = 37;
    random_phase(420);

    set_limit(DEF_MAX_LINE_LEN);
    tx_idle = 0;
    rx_idle = 0;
    random_phase(420);

    // long lines at and one past a mid-sized limit
    set_limit(16'd40);
    long_line(40);
    long_line(41);
    set_limit(16'($urandom_range(65535, 1)));
    random_phase(100);

    drain();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

`default_nettype wire
